>>> design/satm_pkg.sv
// ----------------------------------------------------------------------------
// satm_pkg
// Shared constants and types for the SAD template matcher.
// ----------------------------------------------------------------------------
package satm_pkg;

  localparam int MAX_PATTERN_DEF   = 64;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam int LEN_REG_W = 7;
  localparam int PIDX_W    = 6;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // one accepted sample on its way to the arg-min stage
  typedef struct packed {
    logic vld;
    logic last;
    logic scored;
  } satm_evt_t;

endpackage

>>> design/satm_cell.sv
// ----------------------------------------------------------------------------
// satm_cell
// One cell of the matching row: a pattern element, one history sample and
// a running partial sum handed on to the next cell on every step.
// ----------------------------------------------------------------------------
module satm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int SCORE_W     = 22
) (
  input  logic                          clk,
  input  logic                          step,
  input  logic                          load_en,
  input  logic signed [SAMPLE_BITS-1:0] load_val,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] hist_in,
  output logic signed [SAMPLE_BITS-1:0] hist_out,
  input  logic        [SCORE_W-1:0]     ps_in,
  output logic        [SCORE_W-1:0]     ps_out
);

  logic signed [SAMPLE_BITS-1:0] pat_r;
  logic signed [SAMPLE_BITS-1:0] hist_r;
  logic        [SCORE_W-1:0]     ps_r;
  logic        [SCORE_W-1:0]     ps_nxt;
  logic signed [SAMPLE_BITS:0]   diff;
  logic        [SAMPLE_BITS:0]   mag;

  always_comb begin
    diff   = {x[SAMPLE_BITS-1], x} - {pat_r[SAMPLE_BITS-1], pat_r};
    mag    = diff[SAMPLE_BITS] ? (-diff) : diff;
    // |diff| never exceeds 2^SAMPLE_BITS - 1
    ps_nxt = ps_in + SCORE_W'(mag[SAMPLE_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_r <= load_val;
    end
    if (step) begin
      hist_r <= hist_in;
      ps_r   <= ps_nxt;
    end
  end

  assign hist_out = hist_r;
  assign ps_out   = ps_r;

endmodule

>>> design/satm_argmin.sv
// ----------------------------------------------------------------------------
// satm_argmin
// Running minimum over window scores and the result word register.
// ----------------------------------------------------------------------------
module satm_argmin import satm_pkg::*; #(
  parameter int SCORE_W = 22,
  parameter int POS_W   = 16,
  parameter int LEN_W   = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  satm_evt_t          evt,
  input  logic [POS_W-1:0]   ev_start,
  input  logic [SCORE_W-1:0] score,
  input  logic [LEN_W-1:0]   len_used,
  output logic               hold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_match_found,
  output logic [SCORE_W-1:0] out_min_distance,
  output logic [POS_W-1:0]   out_best_start,
  output logic [POS_W:0]     out_best_end
);

  logic               have_r, have_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [POS_W-1:0]   bpos_r, bpos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;
  logic [SCORE_W-1:0] dist_r, dist_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;
  logic [POS_W:0]     end_r, end_nxt;

  logic               upd;
  logic               advance;
  logic               new_have;
  logic [SCORE_W-1:0] new_best;
  logic [POS_W-1:0]   new_pos;

  assign hold    = evt.vld & evt.last & out_valid_r & out_stall;
  assign advance = evt.vld & ~hold;

  always_comb begin
    // earliest strictly smaller score wins
    upd      = evt.scored & (~have_r | (score < best_r));
    new_have = have_r | evt.scored;
    new_best = upd ? score : best_r;
    new_pos  = upd ? ev_start : bpos_r;

    have_nxt      = have_r;
    best_nxt      = best_r;
    bpos_nxt      = bpos_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    dist_nxt      = dist_r;
    start_nxt     = start_r;
    end_nxt       = end_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      if (evt.last) begin
        out_valid_nxt = 1'b1;
        found_nxt     = new_have;
        dist_nxt      = new_have ? new_best : '0;
        start_nxt     = new_have ? new_pos : '0;
        end_nxt       = new_have ? ((POS_W+1)'(new_pos) + (POS_W+1)'(len_used)) : '0;
        have_nxt      = 1'b0;
        best_nxt      = '1;
        bpos_nxt      = '0;
      end else begin
        have_nxt = new_have;
        best_nxt = new_best;
        bpos_nxt = new_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      best_r      <= '1;
      bpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      best_r      <= best_nxt;
      bpos_r      <= bpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    dist_r  <= dist_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_found  = found_r;
  assign out_min_distance = dist_r;
  assign out_best_start   = start_r;
  assign out_best_end     = end_r;

endmodule

>>> design/sad_template_match_argmin.sv
// Series sample: one word per cycle while in_stall is low; the result word is
//   registered by the arg-min stage once the last sample has entered the cell row.
// While a result word is held off, the next last sample waits and stalls input.
// Pattern load: if a series is open, the cell row is rebuilt from its sample
//   history, which stalls the input until the replay is through.
// Synchronous active-low reset: length 64, search cleared, no result pending.
// ----------------------------------------------------------------------------
// sad_template_match_argmin
// Sum-of-absolute-differences template matcher: a row of cells keeps partial
// window scores, an arg-min stage keeps the earliest best window.
// ----------------------------------------------------------------------------
module sad_template_match_argmin import satm_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  localparam int SCORE_W      = SAMPLE_BITS + $clog2(MAX_PATTERN)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [LEN_REG_W-1:0]          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [PIDX_W-1:0]             in_pattern_index,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_match_found,
  output logic [SCORE_W-1:0]            out_min_distance,
  output logic [POSITION_BITS-1:0]      out_best_start,
  output logic [POSITION_BITS:0]        out_best_end
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  logic [LEN_REG_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 replay_r, replay_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  satm_evt_t            b_evt_r, b_evt_nxt;
  logic [POS_W-1:0]     b_start_r;

  logic [LEN_W-1:0]     len_used;
  logic [IDX_W-1:0]     tap;
  logic                 sample_acc;
  logic                 load_acc;
  logic                 step;
  logic                 hold;
  logic [POS_W-1:0]     pos_inc;
  logic                 scored;
  logic [POS_W-1:0]     start;
  logic signed [SAMPLE_BITS-1:0] x_bcast;

  logic signed [SAMPLE_BITS-1:0] hist [MAX_PATTERN];
  logic        [SCORE_W-1:0]     ps   [MAX_PATTERN];

  always_comb begin
    if (len_r == '0) begin
      len_used = LEN_W'(1);
    end else if (32'(len_r) > MAX_PATTERN) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = LEN_W'(len_r);
    end
    tap = IDX_W'(len_used - LEN_W'(1));
  end

  assign in_stall   = hold | replay_r;
  assign sample_acc = in_valid & ~in_stall & (in_command == CMD_SAMPLE);
  assign load_acc   = in_valid & ~in_stall & (in_command == CMD_LOAD);
  assign step       = sample_acc | replay_r;

  // replay rotates the history through the row, oldest sample first
  assign x_bcast = replay_r ? hist[0] : in_sample_value;

  always_comb begin
    pos_inc = (pos_r == '1) ? pos_r : (pos_r + POS_W'(1));
    scored  = CMP_W'(pos_inc) >= CMP_W'(len_used);
    start   = pos_inc - POS_W'(len_used);
  end

  always_comb begin
    len_nxt    = cfg_wr_en ? cfg_wr_data : len_r;
    pos_nxt    = pos_r;
    replay_nxt = replay_r;
    cnt_nxt    = cnt_r;
    b_evt_nxt  = b_evt_r;

    if (sample_acc) begin
      pos_nxt = in_last_sample ? '0 : pos_inc;
    end

    if (replay_r) begin
      cnt_nxt = cnt_r - IDX_W'(1);
      if (cnt_r == '0) begin
        replay_nxt = 1'b0;
      end
    end else if (load_acc && (pos_r != '0)) begin
      replay_nxt = 1'b1;
      cnt_nxt    = IDX_W'(MAX_PATTERN - 1);
    end

    if (!hold) begin
      b_evt_nxt.vld    = sample_acc;
      b_evt_nxt.last   = in_last_sample;
      b_evt_nxt.scored = scored;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_RESET;
      pos_r    <= '0;
      replay_r <= 1'b0;
      cnt_r    <= '0;
      b_evt_r  <= '0;
    end else begin
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      replay_r <= replay_nxt;
      cnt_r    <= cnt_nxt;
      b_evt_r  <= b_evt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      b_start_r <= start;
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] hist_in;
    logic        [SCORE_W-1:0]     ps_in;
    logic                          load_en;

    assign load_en = load_acc & (32'(in_pattern_index) == k);

    if (k == MAX_PATTERN - 1) begin : g_tail
      assign hist_in = x_bcast;
    end else begin : g_body
      assign hist_in = hist[k+1];
    end

    if (k == 0) begin : g_head
      assign ps_in = '0;
    end else begin : g_link
      assign ps_in = ps[k-1];
    end

    satm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SCORE_W     (SCORE_W)
    ) u_cell (
      .clk      (clk),
      .step     (step),
      .load_en  (load_en),
      .load_val (in_sample_value),
      .x        (x_bcast),
      .hist_in  (hist_in),
      .hist_out (hist[k]),
      .ps_in    (ps_in),
      .ps_out   (ps[k])
    );
  end

  satm_argmin #(
    .SCORE_W (SCORE_W),
    .POS_W   (POS_W),
    .LEN_W   (LEN_W)
  ) u_argmin (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt              (b_evt_r),
    .ev_start         (b_start_r),
    .score            (ps[tap]),
    .len_used         (len_used),
    .hold             (hold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_found  (out_match_found),
    .out_min_distance (out_min_distance),
    .out_best_start   (out_best_start),
    .out_best_end     (out_best_end)
  );

endmodule
